// ===== rtl/sir90_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_pkg
// Shared constants, codes, a helper function and control types for the
// square frame store with 90 degree clockwise rotation.
// ----------------------------------------------------------------------------
package sir90_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int PIXEL_WIDTH = 32;
	localparam int FIELD_W     = 32;
	localparam int SIDE_W      = 7;
	localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int IDX_W       = $clog2(MAX_SIDE);
	localparam int ACT_W       = IDX_W + 1;
	localparam int SIDE_RESET  = 64;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ROTATE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic load;
		logic read;
		logic rot_start;
		logic rot_run;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic rot_none;
		logic rot_done;
	} dp_stat_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [ACT_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [ACT_W-1:0] res;
		if (v == '0) begin
			res = ACT_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			res = ACT_W'(MAX_SIDE);
		end else begin
			res = ACT_W'(v);
		end
		return res;
	endfunction

endpackage

// ===== rtl/sir90_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_req_if
// Request channel: command and pixel word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sir90_req_if;
	import sir90_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [FIELD_W-1:0] pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

// ===== rtl/sir90_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_rsp_if
// Response channel: read pixel and last flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sir90_rsp_if;
	import sir90_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] pixel_out;
	logic               last;

	modport source (output valid, output pixel_out, output last, input ready);
	modport sink   (input valid, input pixel_out, input last, output ready);
endinterface

// ===== rtl/sir90_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_ctrl
// Controller: accepts requests, decodes commands and sequences a rotation.
// ----------------------------------------------------------------------------
module sir90_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [1:0]         req_cmd,
	output logic               req_ready,
	output sir90_pkg::dp_cmd_t dcmd,
	input  sir90_pkg::dp_stat_t dstat
);
	import sir90_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_ROTATE = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE) && dstat.slot_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		dcmd.load      = accept && (req_cmd == CMD_LOAD);
		dcmd.read      = accept && (req_cmd == CMD_READ);
		dcmd.rot_start = accept && (req_cmd == CMD_ROTATE);
		dcmd.rot_run   = (state_q == ST_ROTATE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dcmd.rot_start && !dstat.rot_none) begin
					state_d = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				if (dstat.rot_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/sir90_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_datapath
// Datapath: frame memory, pointers, side register, orbit counters and
// the response register stage.
// ----------------------------------------------------------------------------
module sir90_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sir90_pkg::SIDE_W-1:0]  cfg_wdata,
	input  logic [sir90_pkg::FIELD_W-1:0] req_pixel,
	input  sir90_pkg::dp_cmd_t            dcmd,
	output sir90_pkg::dp_stat_t           dstat,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [sir90_pkg::FIELD_W-1:0] rsp_pixel,
	output logic                          rsp_last
);
	import sir90_pkg::*;

	logic [PIXEL_WIDTH-1:0] mem [DEPTH];
	logic [PIXEL_WIDTH-1:0] rd_data_q;
	logic [PIXEL_WIDTH-1:0] hold_q [3];

	logic [ACT_W-1:0]   side_q;
	logic [COUNT_W-1:0] count_q;
	logic [ACT_W-1:0]   cfg_side;
	logic [ADDR_W-1:0]  wr_ptr_q;
	logic [ADDR_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]   r_q;
	logic [IDX_W-1:0]   c_q;
	logic [2:0]         step_q;

	logic [ACT_W-1:0]   r_end;
	logic [ACT_W-1:0]   c_end;
	logic [IDX_W-1:0]   side_m1;
	logic [IDX_W-1:0]   row;
	logic [IDX_W-1:0]   col;
	logic [ADDR_W-1:0]  rot_addr;
	logic               c_wrap;
	logic               r_wrap;

	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [PIXEL_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_raddr;

	logic               pend_q;
	logic               pend_last_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_pixel_q;
	logic               out_last_q;
	logic               move;
	logic               rd_last;

	function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p,
			input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] n;
		n = {1'b0, p} + COUNT_W'(1);
		return (n >= cnt) ? '0 : n[ADDR_W-1:0];
	endfunction

	// side register and pixel count
	assign cfg_side = clamp_side(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= clamp_side(SIDE_W'(SIDE_RESET));
			count_q <= COUNT_W'(DEPTH);
		end else if (cfg_we) begin
			side_q  <= cfg_side;
			count_q <= COUNT_W'(COUNT_W'(cfg_side) * COUNT_W'(cfg_side));
		end
	end

	// orbit addressing
	assign r_end   = side_q >> 1;
	assign c_end   = ACT_W'(({1'b0, side_q} + (ACT_W + 1)'(1)) >> 1);
	assign side_m1 = IDX_W'(side_q - ACT_W'(1));
	assign c_wrap  = ({1'b0, c_q} + ACT_W'(1)) == c_end;
	assign r_wrap  = ({1'b0, r_q} + ACT_W'(1)) == r_end;

	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				row = r_q;
				col = c_q;
			end
			2'd1: begin
				row = c_q;
				col = side_m1 - r_q;
			end
			2'd2: begin
				row = side_m1 - r_q;
				col = side_m1 - c_q;
			end
			default: begin
				row = side_m1 - c_q;
				col = r_q;
			end
		endcase
	end

	assign rot_addr = ADDR_W'(COUNT_W'(row) * COUNT_W'(side_q) + COUNT_W'(col));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			c_q    <= '0;
			step_q <= '0;
		end else if (dcmd.rot_start) begin
			r_q    <= '0;
			c_q    <= '0;
			step_q <= '0;
		end else if (dcmd.rot_run) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				if (c_wrap) begin
					c_q <= '0;
					r_q <= r_q + IDX_W'(1);
				end else begin
					c_q <= c_q + IDX_W'(1);
				end
			end
		end
	end

	// hold the first three orbit pixels
	always_ff @(posedge clk) begin
		if (dcmd.rot_run) begin
			case (step_q)
				3'd1: hold_q[0] <= rd_data_q;
				3'd2: hold_q[1] <= rd_data_q;
				3'd3: hold_q[2] <= rd_data_q;
				default: begin
				end
			endcase
		end
	end

	// memory port selection
	always_comb begin
		mem_we    = dcmd.load || (dcmd.rot_run && step_q[2]);
		mem_waddr = dcmd.rot_run ? rot_addr : wr_ptr_q;
		mem_re    = dcmd.read || (dcmd.rot_run && !step_q[2]);
		mem_raddr = dcmd.rot_run ? rot_addr : rd_ptr_q;
		if (dcmd.rot_run) begin
			case (step_q[1:0])
				2'd0:    mem_wdata = rd_data_q;
				2'd1:    mem_wdata = hold_q[0];
				2'd2:    mem_wdata = hold_q[1];
				default: mem_wdata = hold_q[2];
			endcase
		end else begin
			mem_wdata = PIXEL_WIDTH'(req_pixel);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// pointers
	assign rd_last = ({1'b0, rd_ptr_q} + COUNT_W'(1)) >= count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (dcmd.rot_start) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (dcmd.load) begin
				wr_ptr_q <= next_ptr(wr_ptr_q, count_q);
			end
			if (dcmd.read) begin
				rd_ptr_q <= next_ptr(rd_ptr_q, count_q);
			end
		end
	end

	// response stage
	assign move = pend_q && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dcmd.read) begin
				pend_q <= 1'b1;
			end else if (move) begin
				pend_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.read) begin
			pend_last_q <= rd_last;
		end
		if (move) begin
			out_pixel_q <= FIELD_W'(rd_data_q);
			out_last_q  <= pend_last_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_pixel = out_pixel_q;
	assign rsp_last  = out_last_q;

	always_comb begin
		dstat.slot_free = !pend_q || move;
		dstat.rot_none  = side_q < ACT_W'(2);
		dstat.rot_done  = dcmd.rot_run && (step_q == 3'd7) && c_wrap && r_wrap;
	end
endmodule

// ===== rtl/square_image_rotate_90_in_place_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_image_rotate_90_in_place_unit
// Square frame store with in-place 90 degree clockwise rotation.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, pixel_in
//   rsp      out  valid/ready    pixel_out, last
//   cfg      in   cfg_we         cfg_wdata (matrix side)
//
// Loads and reads may follow back to back while req.ready is high.
// Rotate holds req.ready low until all floor(s/2) * ceil(s/2) orbits are done:
// each orbit reads four pixels then writes four through the single write and
// single read port of the frame memory.
// The response register decouples rsp stalls; a full response stage stalls req.
// Reset sets side to SIDE_RESET, clears pointers; frame memory is not cleared.
// ----------------------------------------------------------------------------
module square_image_rotate_90_in_place_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sir90_pkg::SIDE_W-1:0] cfg_wdata,
	sir90_req_if.sink                    req,
	sir90_rsp_if.source                  rsp
);
	import sir90_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	sir90_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.dcmd      (dcmd),
		.dstat     (dstat)
	);

	sir90_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_pixel (req.pixel_in),
		.dcmd      (dcmd),
		.dstat     (dstat),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_pixel (rsp.pixel_out),
		.rsp_last  (rsp.last)
	);
endmodule

// ===== tb/sv/tb_square_image_rotate_90_in_place_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_image_rotate_90_in_place_unit
// Self-checking bench for the square frame store with in-place clockwise
// rotation. Requests are sent through the request channel. A behavioural
// copy of the frame, its pointers and the side register predicts every read.
// Each returned pixel and last flag is compared with the oldest prediction.
// The side register is changed only while the block is idle. Reads are
// issued only for entries that have been loaded.
// ----------------------------------------------------------------------------
module tb_square_image_rotate_90_in_place_unit;
	import sir90_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT  = 1_000_000;
	localparam int         RANDOM_ITEMS = 1150;
	localparam int         IDLE_PCT     = 14;

	typedef struct {
		logic [FIELD_W-1:0] pixel;
		logic               last;
	} read_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [SIDE_W-1:0]  cfg_wdata;

	sir90_req_if req_ch ();
	sir90_rsp_if rsp_ch ();

	square_image_rotate_90_in_place_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [FIELD_W-1:0] frame_copy [0:DEPTH-1];
	bit                 frame_known [0:DEPTH-1];
	int                 load_ptr;
	int                 read_ptr;
	logic [SIDE_W-1:0]  side_reg;
	read_word_t         read_queue [$];
	read_word_t         want;
	bit                 calm;
	int                 errors;
	int                 requests_sent;
	int                 cycle_count;

	always #4 clk = ~clk;

	function automatic int active_side();
		if (side_reg == '0) return 1;
		if (int'(side_reg) > MAX_SIDE) return MAX_SIDE;
		return int'(side_reg);
	endfunction

	function automatic int rotate_cycles();
		int s;
		s = active_side();
		return 8 * (s / 2) * ((s + 1) / 2) + 16;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	task automatic predict_frame_op(input logic [1:0] op, input logic [FIELD_W-1:0] px);
		int s;
		int count;
		int a, b, d, e;
		logic [FIELD_W-1:0] held;
		bit held_known;
		read_word_t w;
		s = active_side();
		count = s * s;
		case (op)
			CMD_LOAD: begin
				frame_copy[load_ptr]  = px;
				frame_known[load_ptr] = 1'b1;
				load_ptr = (load_ptr + 1 >= count) ? 0 : load_ptr + 1;
			end
			CMD_ROTATE: begin
				for (int r = 0; r < s / 2; r++) begin
					for (int c = 0; c < (s + 1) / 2; c++) begin
						a = r * s + c;
						b = c * s + (s - 1 - r);
						d = (s - 1 - r) * s + (s - 1 - c);
						e = (s - 1 - c) * s + r;
						held           = frame_copy[e];
						held_known     = frame_known[e];
						frame_copy[e]  = frame_copy[d];
						frame_known[e] = frame_known[d];
						frame_copy[d]  = frame_copy[b];
						frame_known[d] = frame_known[b];
						frame_copy[b]  = frame_copy[a];
						frame_known[b] = frame_known[a];
						frame_copy[a]  = held;
						frame_known[a] = held_known;
					end
				end
				load_ptr = 0;
				read_ptr = 0;
			end
			CMD_READ: begin
				w.pixel = frame_copy[read_ptr];
				w.last  = (read_ptr + 1 >= count);
				read_queue.push_back(w);
				read_ptr = (read_ptr + 1 >= count) ? 0 : read_ptr + 1;
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_request(input logic [1:0] op, input logic [FIELD_W-1:0] px);
		while (idle_now()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= op;
		req_ch.pixel_in <= px;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_frame_op(op, px);
		if (op != CMD_UNUSED) requests_sent++;
	endtask

	task automatic set_side(input logic [SIDE_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (read_queue.size() != 0) @(posedge clk);
		repeat (rotate_cycles()) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		side_reg  = v;
	endtask

	task automatic test_reset_side_loads();
		send_request(CMD_LOAD, 32'h0000_0000);
		send_request(CMD_LOAD, 32'hFFFF_FFFF);
		send_request(CMD_READ, $urandom());
		send_request(CMD_READ, $urandom());
		send_request(CMD_UNUSED, $urandom());
	endtask

	task automatic test_shrink_past_end();
		send_request(CMD_LOAD, 32'hAAAA_AAAA);
		send_request(CMD_LOAD, 32'h5555_5555);
		send_request(CMD_LOAD, $urandom());
		send_request(CMD_LOAD, $urandom());
		repeat (3) send_request(CMD_READ, $urandom());
		set_side(7'd2);
		send_request(CMD_LOAD, $urandom());
		send_request(CMD_READ, $urandom());
		send_request(CMD_READ, $urandom());
	endtask

	task automatic test_side_zero();
		set_side(7'd0);
		send_request(CMD_ROTATE, $urandom());
		send_request(CMD_LOAD, $urandom());
		send_request(CMD_READ, $urandom());
		send_request(CMD_READ, $urandom());
	endtask

	task automatic test_side_clamp_high();
		set_side(7'h7F);
		repeat (4) send_request(CMD_ROTATE, $urandom());
		send_request(CMD_READ, $urandom());
		send_request(CMD_READ, $urandom());
	endtask

	task automatic test_random_frames();
		int phase;
		int large_left;
		int roll;
		int s;
		int n;
		int rots;
		int k;
		logic [1:0] op;
		phase         = 0;
		large_left    = 3;
		requests_sent = 0;
		while (requests_sent < RANDOM_ITEMS) begin
			calm = (phase >= 4 && phase < 8);
			if (phase == 0) begin
				set_side(7'd3);
			end else if (phase == 1) begin
				set_side(7'd4);
			end else begin
				roll = $urandom_range(99);
				if (roll < 4) begin
					set_side(7'd0);
				end else if (roll < 10 && large_left > 0) begin
					large_left--;
					set_side(SIDE_W'($urandom_range(64, 127)));
				end else begin
					set_side(SIDE_W'($urandom_range(1, 12)));
				end
			end
			s = active_side();
			if (phase < 2 || $urandom_range(99) < 75) begin
				n    = (s <= 16) ? s * s : $urandom_range(20, 48);
				rots = (s <= 16) ? $urandom_range(1, 3) : 4;
				if ($urandom_range(9) == 0) n = $urandom_range(1, n);
				send_request(CMD_ROTATE, $urandom());
				repeat (n) send_request(CMD_LOAD, $urandom());
				repeat (rots) send_request(CMD_ROTATE, $urandom());
				k = 0;
				while (k < n && frame_known[read_ptr]) begin
					send_request(CMD_READ, $urandom());
					k++;
				end
			end else begin
				repeat ($urandom_range(20, 40)) begin
					op = 2'($urandom_range(3));
					if (op == CMD_ROTATE && (s > 16 || $urandom_range(3) != 0)) op = CMD_LOAD;
					if (op == CMD_READ && !frame_known[read_ptr]) op = CMD_LOAD;
					send_request(op, $urandom());
				end
			end
			phase++;
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= !idle_now();
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (read_queue.size() == 0) begin
				$display("%0t unexpected response: expected none actual pixel %h last %b",
					$time, rsp_ch.pixel_out, rsp_ch.last);
				errors++;
			end else begin
				want = read_queue.pop_front();
				if (rsp_ch.pixel_out !== want.pixel) begin
					$display("%0t pixel_out: expected %h actual %h",
						$time, want.pixel, rsp_ch.pixel_out);
					errors++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t last: expected %b actual %b", $time, want.last, rsp_ch.last);
					errors++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.cmd      <= CMD_LOAD;
		req_ch.pixel_in <= '0;
		calm     = 1'b0;
		errors   = 0;
		load_ptr = 0;
		read_ptr = 0;
		side_reg = SIDE_W'(SIDE_RESET);
		for (int i = 0; i < DEPTH; i++) frame_known[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_side_loads();
		test_shrink_past_end();
		test_side_zero();
		test_side_clamp_high();
		test_random_frames();
		// drain outstanding reads and any rotation still in progress
		req_ch.valid <= 1'b0;
		while (read_queue.size() != 0) @(posedge clk);
		repeat (rotate_cycles()) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
